// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

// ----- src/hsid_pkg.sv -----
// ---------------------------------------------------------------------------
// hsid_pkg
// Types and constants of the half-size image downscaler.
// ---------------------------------------------------------------------------
package hsid_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned LW_W    = 12;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LW_W-1:0]   LINE_WIDTH_RST = 12'd720;
  localparam logic [MODE_W-1:0] H_MODE_RST     = 2'd1;
  localparam logic [MODE_W-1:0] V_MODE_RST     = 2'd1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH = 2'd0,
    REG_H_MODE     = 2'd1,
    REG_V_MODE     = 2'd2
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    H_DECIM  = 2'd0,
    H_TAP121 = 2'd1,
    H_TAP11  = 2'd2
  } h_mode_e;

  typedef enum logic [MODE_W-1:0] {
    V_OFF    = 2'd0,
    V_TAP121 = 2'd1,
    V_TAP11  = 2'd2
  } v_mode_e;

  // Horizontal stage result
  typedef struct packed {
    logic             have;
    logic [PIX_W-1:0] h;
  } hsid_hres_t;

  // Column position flags for the horizontal stage
  typedef struct packed {
    logic even;
    logic zero;
    logic last;
  } hsid_col_t;

  function automatic h_mode_e hsid_h_mode(input logic [MODE_W-1:0] raw);
    h_mode_e m;
    case (raw)
      2'd1:    m = H_TAP121;
      2'd2:    m = H_TAP11;
      default: m = H_DECIM;
    endcase
    return m;
  endfunction

  function automatic v_mode_e hsid_v_mode(input logic [MODE_W-1:0] raw);
    v_mode_e m;
    case (raw)
      2'd1:    m = V_TAP121;
      2'd2:    m = V_TAP11;
      default: m = V_OFF;
    endcase
    return m;
  endfunction

endpackage

// ----- src/hsid_line_store.sv -----
// ---------------------------------------------------------------------------
// hsid_line_store
// One line of filtered samples: single write port, registered read port.
// ---------------------------------------------------------------------------
module hsid_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic         clk_i,
  input  logic         we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]   wdata_i,
  input  logic         re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/hsid_hstage.sv -----
// ---------------------------------------------------------------------------
// hsid_hstage
// Horizontal filter: decimate, taps 1-1 or taps 1-2-1 with edge repeat.
// ---------------------------------------------------------------------------
module hsid_hstage import hsid_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  h_mode_e          mode_i,
  input  hsid_col_t        col_i,
  input  logic [PIX_W-1:0] pixel_i,
  output hsid_hres_t       res_o
);

  logic [PIX_W-1:0] a_q, a_d;
  logic [PIX_W-1:0] b_q, b_d;
  logic [PIX_W+1:0] sum121, sum3, sum11;

  assign sum121 = {2'b00, a_q} + {1'b0, b_q, 1'b0} + {2'b00, pixel_i};
  assign sum3   = {2'b00, a_q} + {1'b0, pixel_i, 1'b0} + {2'b00, pixel_i};
  assign sum11  = {2'b00, a_q} + {2'b00, pixel_i};

  always_comb begin
    a_d        = a_q;
    b_d        = b_q;
    res_o.have = 1'b0;
    res_o.h    = pixel_i;
    unique case (mode_i)
      H_TAP121: begin
        if (col_i.even) begin
          res_o.have = !col_i.zero;
          res_o.h    = sum121[PIX_W+1:2];
          a_d        = pixel_i;
        end else begin
          b_d        = pixel_i;
          res_o.have = col_i.last;          // right edge repeats last sample
          res_o.h    = sum3[PIX_W+1:2];
        end
      end
      H_TAP11: begin
        if (col_i.even) begin
          a_d = pixel_i;
        end else begin
          res_o.have = 1'b1;
          res_o.h    = sum11[PIX_W:1];
        end
      end
      default: begin
        res_o.have = col_i.even;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

endmodule

// ----- src/half_size_image_downscaler.sv -----
// ---------------------------------------------------------------------------
// half_size_image_downscaler
// Halves one 8-bit plane in width and height with selectable 2x filters.
// ---------------------------------------------------------------------------
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata pixel_in, tuser
//            |     |                               | frame_start
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata pixel_out, tlast
//            |     |                               | line_last
//  cfg       | in  | cfg_we_i (always taken)       | cfg_idx_i, cfg_wdata_i
//
//  One sample accepted per clock unless the output stalls. The sample
//  that completes a result is registered in stage 1 alongside the line
//  store read, then the result in the output register. Only output
//  back-pressure limits throughput. Reset clears config to defaults and
//  the position counters; line stores are not cleared.
//  Output stall backs up through the two pipeline registers to s_axis_tready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module half_size_image_downscaler import hsid_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] pixel_in
  input  logic                 s_axis_tuser,   // [0] frame_start
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] pixel_out
  output logic                 m_axis_tlast,   // line_last
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LW_W-1:0]      cfg_wdata_i
);

  localparam int unsigned HALF = MAX_WIDTH / 2;
  localparam int unsigned KW   = $clog2(HALF);           // line store address
  localparam int unsigned CW   = $clog2(MAX_WIDTH + 1);  // column / width
  localparam int unsigned EW   = (CW > LW_W) ? CW : LW_W;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [LW_W-1:0]   lw_q;
  logic [MODE_W-1:0] hm_q, vm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= LINE_WIDTH_RST;
      hm_q <= H_MODE_RST;
      vm_q <= V_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_WIDTH: lw_q <= cfg_wdata_i;
        REG_H_MODE:     hm_q <= cfg_wdata_i[MODE_W-1:0];
        REG_V_MODE:     vm_q <= cfg_wdata_i[MODE_W-1:0];
        default: ;                           // unmapped index ignored
      endcase
    end
  end

  h_mode_e hm;
  v_mode_e vm;
  assign hm = hsid_h_mode(hm_q);
  assign vm = hsid_v_mode(vm_q);

  // effective width: even, clamped to 2 .. MAX_WIDTH
  logic [EW-1:0] lw_ext, wmax_ext, w_ext;
  logic [CW-1:0] w;

  assign lw_ext   = EW'(lw_q) & ~EW'(1);
  assign wmax_ext = EW'(MAX_WIDTH) & ~EW'(1);
  always_comb begin
    if (lw_ext < EW'(2))        w_ext = EW'(2);
    else if (lw_ext > wmax_ext) w_ext = wmax_ext;
    else                        w_ext = lw_ext;
  end
  assign w = w_ext[CW-1:0];

  // -------------------------------------------------------------------------
  // Handshake and pipeline control
  // -------------------------------------------------------------------------
  logic in_acc, out_free, s1_free;
  logic s1_v_q, m_v_q;

  assign out_free      = !m_v_q || m_axis_tready;
  assign s1_free       = !s1_v_q || out_free;
  assign s_axis_tready = s1_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // -------------------------------------------------------------------------
  // Raster position
  // -------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d, col_cur, c;
  logic          odd_q, odd_d, odd_cur;
  logic          first_q, first_d, first_cur;
  logic          c_last;

  // frame start restarts the position before this sample is used
  assign col_cur   = s_axis_tuser ? '0 : col_q;
  assign odd_cur   = s_axis_tuser ? 1'b0 : odd_q;
  assign first_cur = s_axis_tuser ? 1'b1 : first_q;
  assign c         = (col_cur >= w) ? '0 : col_cur;   // wrap after width change
  assign c_last    = (c == w - CW'(1));

  assign col_d   = c_last ? '0 : c + CW'(1);
  assign odd_d   = c_last ? !odd_cur : odd_cur;
  assign first_d = (c_last && odd_cur) ? 1'b0 : first_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      odd_q   <= 1'b0;
      first_q <= 1'b1;
    end else if (in_acc) begin
      col_q   <= col_d;
      odd_q   <= odd_d;
      first_q <= first_d;
    end
  end

  // -------------------------------------------------------------------------
  // Horizontal stage
  // -------------------------------------------------------------------------
  hsid_col_t  col_flags;
  hsid_hres_t hres;
  logic [KW-1:0] k_c, k;

  assign col_flags.even = !c[0];
  assign col_flags.zero = (c == '0);
  assign col_flags.last = c_last;

  hsid_hstage u_hstage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (in_acc),
    .mode_i  (hm),
    .col_i   (col_flags),
    .pixel_i (s_axis_tdata),
    .res_o   (hres)
  );

  // 1-2-1 centers on the previous pair when it completes on an even column
  assign k_c = KW'(c >> 1);
  assign k   = (hm == H_TAP121 && col_flags.even) ? k_c - KW'(1) : k_c;

  // -------------------------------------------------------------------------
  // Line stores: even row H, and previous odd row H for the 1-2-1 mode
  // -------------------------------------------------------------------------
  logic       even_we, odd_we, emit;
  logic [7:0] even_rd, odd_rd;

  assign even_we = in_acc && hres.have && (vm != V_OFF) && !odd_cur;
  assign odd_we  = in_acc && hres.have && (vm == V_TAP121) && odd_cur;
  assign emit    = hres.have && ((vm == V_OFF) ? !odd_cur : odd_cur);

  hsid_line_store #(.DEPTH(HALF), .AW(KW)) u_even_store (
    .clk_i   (clk_i),
    .we_i    (even_we),
    .waddr_i (k),
    .wdata_i (hres.h),
    .re_i    (in_acc),
    .raddr_i (k),
    .rdata_o (even_rd)
  );

  hsid_line_store #(.DEPTH(HALF), .AW(KW)) u_odd_store (
    .clk_i   (clk_i),
    .we_i    (odd_we),
    .waddr_i (k),
    .wdata_i (hres.h),
    .re_i    (in_acc),
    .raddr_i (k),
    .rdata_o (odd_rd)
  );

  // -------------------------------------------------------------------------
  // Stage 1 register: H sample and vertical context, store data alongside
  // -------------------------------------------------------------------------
  logic [7:0] s1_h_q;
  v_mode_e    s1_vm_q;
  logic       s1_first_q, s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= emit;
    end else if (out_free) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_h_q     <= hres.h;
      s1_vm_q    <= vm;
      s1_first_q <= first_cur;                        // top edge repeats row 0
      s1_last_q  <= (k == KW'((w >> 1) - CW'(1)));
    end
  end

  // -------------------------------------------------------------------------
  // Vertical stage into the output register
  // -------------------------------------------------------------------------
  logic [7:0] prev_h, v;
  logic [9:0] vsum121, vsum11;

  assign prev_h  = s1_first_q ? even_rd : odd_rd;
  assign vsum121 = {2'b00, prev_h} + {1'b0, even_rd, 1'b0} + {2'b00, s1_h_q};
  assign vsum11  = {2'b00, even_rd} + {2'b00, s1_h_q};

  always_comb begin
    unique case (s1_vm_q)
      V_TAP121: v = vsum121[9:2];
      V_TAP11:  v = vsum11[8:1];
      default:  v = s1_h_q;
    endcase
  end

  logic [7:0] m_data_q;
  logic       m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (out_free) begin
      m_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_v_q) begin
      m_data_q <= v;
      m_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_NEVER(a_col_range, clk_i, rst_ni, col_q >= CW'(MAX_WIDTH),
                "column counter out of range")
  `ASSERT_PROP(a_frame_restart, clk_i, rst_ni,
               (in_acc && s_axis_tuser) |=> (col_q == CW'(1) && !odd_q),
               "frame start did not restart the raster position")
  `ASSERT_PROP(a_ready_when_empty, clk_i, rst_ni, !m_v_q |-> s_axis_tready,
               "input stalled with an empty output register")
  `ASSERT_PROP(a_emit_reaches_s1, clk_i, rst_ni, (in_acc && emit) |=> s1_v_q,
               "completed sample lost between input and stage 1")

endmodule
